@@ rtl/core/multi_pool_block_allocator_core_defines.svh @@
// Assertion macros shared by the multi-pool block allocator RTL.
`ifndef MULTI_POOL_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define MULTI_POOL_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent and consequent are checked in the same cycle.
`define MPBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpba assertion failed (same cycle)");
// The consequent is checked in the cycle after the antecedent.
`define MPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpba assertion failed (next cycle)");
`else
`define MPBA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MPBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/mpba_pkg.sv @@
// Package with field widths, command and status codes for the block allocator.
`default_nettype none
package mpba_pkg;

  localparam int CMD_W    = 2;
  localparam int POOL_W   = 3;
  localparam int BLOCK_W  = 6;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 6;
  localparam int USE_W    = 7;
  localparam int CNT_W    = 7;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam int CFG_REGS  = 7;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(8);

  localparam logic [CMD_W-1:0] CMD_INIT  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ALLOC = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_FREE  = CMD_W'(2);

  localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = STATUS_W'(2);

endpackage
`default_nettype wire

@@ rtl/core/mpba_intf.sv @@
// Request and response channel interfaces of the block allocator.
`default_nettype none
interface mpba_req_if;
  logic                          valid;
  logic                          ready;
  logic [mpba_pkg::CMD_W-1:0]    cmd;
  logic [mpba_pkg::POOL_W-1:0]   pool;
  logic [mpba_pkg::BLOCK_W-1:0]  block;

  modport source (output valid, output cmd, output pool, output block, input ready);
  modport sink (input valid, input cmd, input pool, input block, output ready);
endinterface

interface mpba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [mpba_pkg::STATUS_W-1:0]  status;
  logic [mpba_pkg::GRANT_W-1:0]   granted_block;
  logic [mpba_pkg::USE_W-1:0]     blocks_in_use;

  modport source (output valid, output status, output granted_block, output blocks_in_use,
                  input ready);
  modport sink (input valid, input status, input granted_block, input blocks_in_use,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/multi_pool_block_allocator_core.sv @@
// Multi-pool block allocator: one LIFO free list per pool over a shared link memory.
// Each request transaction is processed alone; the block is not ready until the result
// has been moved into the output register, which may still be waiting for the consumer.
// Allocate and free pass through their own state and then ST_OUT; the unused command goes
// straight to ST_OUT. Init sums the counts in ST_SUM, checks the total in ST_CHECK and
// carves each pool in ST_CARVE; when the counts overflow the store it answers from
// ST_CHECK without carving. The init time is set by the single write port of the link
// memory, filled one entry per cycle, and by the one adder that first sums the counts and
// then steps the carve position. There is no clearing pass after reset: link entries are
// written by init or free before any read can use them.
`default_nettype none
`include "multi_pool_block_allocator_core_defines.svh"
module multi_pool_block_allocator_core #(
  parameter int NUM_POOLS    = 7,
  parameter int TOTAL_BLOCKS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  mpba_req_if.sink                          req,
  mpba_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mpba_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mpba_pkg::APB_DW-1:0]  pwdata,
  output logic      [mpba_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int LW    = $clog2(TOTAL_BLOCKS + 1);
  localparam int AW    = $clog2(TOTAL_BLOCKS);
  localparam int SUM_A = mpba_pkg::CNT_W + PW + 1;
  localparam int SUMW  = (SUM_A > LW + 1) ? SUM_A : LW + 1;
  localparam int HEADS = 2 ** PW;
  localparam logic [LW-1:0] NULL_IDX = LW'(TOTAL_BLOCKS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_CHECK, ST_CARVE, ST_ALLOC, ST_FREE, ST_OUT
  } state_t;

  state_t state;

  logic [NUM_POOLS-1:0][mpba_pkg::CNT_W-1:0] counts;

  logic [mpba_pkg::POOL_W-1:0]  pool_q;
  logic [mpba_pkg::BLOCK_W-1:0] blk_q;
  logic [PW-1:0]                pidx;
  logic [mpba_pkg::CNT_W-1:0]   kcnt;
  logic [LW-1:0]                pos;
  logic [SUMW-1:0]              acc;
  logic [LW-1:0]                use_cnt;
  logic [LW-1:0]                heads [HEADS];

  logic [mpba_pkg::STATUS_W-1:0] res_status;
  logic [LW-1:0]                 res_grant;

  logic                          rsp_valid;
  logic [mpba_pkg::STATUS_W-1:0] rsp_status;
  logic [mpba_pkg::GRANT_W-1:0]  rsp_grant;
  logic [mpba_pkg::USE_W-1:0]    rsp_use;
  logic                          rsp_err;

  // Shared adder: sums the pool counts, then steps the carve position.
  logic [SUMW-1:0] add_a;
  logic [SUMW-1:0] add_b;
  logic [SUMW-1:0] add_sum;

  logic [mpba_pkg::CNT_W-1:0] cur_cnt;
  logic                       carve_last;
  logic                       pool_ok;
  logic                       blk_ok;
  logic [LW-1:0]              head_sel;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  mpba_cfg #(
    .NUM_POOLS (NUM_POOLS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .counts  (counts)
  );

  mpba_ram #(
    .WIDTH (LW),
    .DEPTH (TOTAL_BLOCKS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pready    = 1'b1;
  assign req.ready = (state == ST_IDLE);

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.granted_block = rsp_grant;
  assign rsp.blocks_in_use = rsp_use;
  assign rsp_err           = (rsp_status != mpba_pkg::STATUS_OK);

  assign cur_cnt    = counts[pidx];
  assign carve_last = (kcnt == cur_cnt - mpba_pkg::CNT_W'(1));
  assign pool_ok    = (32'(pool_q) < 32'(NUM_POOLS));
  assign blk_ok     = (32'(blk_q) < 32'(TOTAL_BLOCKS));
  assign head_sel   = heads[pool_q[PW-1:0]];

  // The head of the requested pool is looked up while the request is accepted,
  // so its link is ready in the following cycle.
  assign ram_raddr = AW'(heads[req.pool[PW-1:0]]);

  always_comb begin
    if (state == ST_SUM) begin
      add_a = acc;
      add_b = SUMW'(cur_cnt);
    end else begin
      add_a = SUMW'(pos);
      add_b = SUMW'(1);
    end
    add_sum = add_a + add_b;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(pos);
    ram_wdata = carve_last ? NULL_IDX : LW'(add_sum);
    case (state)
      ST_CARVE: begin
        ram_we = (cur_cnt != '0);
      end
      ST_FREE: begin
        ram_we    = pool_ok && blk_ok;
        ram_waddr = AW'(blk_q);
        ram_wdata = head_sel;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      use_cnt   <= '0;
      for (int i = 0; i < HEADS; i++) begin
        heads[i] <= NULL_IDX;
      end
    end else begin
      // In ST_OUT the output register is either reloaded or left holding its transaction.
      if (rsp.ready && state != ST_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            pool_q <= req.pool;
            blk_q  <= req.block;
            pidx   <= '0;
            acc    <= '0;
            case (req.cmd)
              mpba_pkg::CMD_INIT:  state <= ST_SUM;
              mpba_pkg::CMD_ALLOC: state <= ST_ALLOC;
              mpba_pkg::CMD_FREE:  state <= ST_FREE;
              default: begin
                res_status <= mpba_pkg::STATUS_OK;
                res_grant  <= '0;
                state      <= ST_OUT;
              end
            endcase
          end
        end
        ST_SUM: begin
          acc <= add_sum;
          if (pidx == PW'(NUM_POOLS - 1)) begin
            state <= ST_CHECK;
          end else begin
            pidx <= pidx + PW'(1);
          end
        end
        ST_CHECK: begin
          pidx <= '0;
          kcnt <= '0;
          pos  <= '0;
          res_grant <= '0;
          if (32'(acc) > 32'(TOTAL_BLOCKS)) begin
            res_status <= mpba_pkg::STATUS_OVERFLOW;
            state      <= ST_OUT;
          end else begin
            res_status <= mpba_pkg::STATUS_OK;
            state      <= ST_CARVE;
          end
        end
        ST_CARVE: begin
          if (cur_cnt == '0 || carve_last) begin
            // Current pool is finished; move on or complete the init.
            kcnt <= '0;
            if (pidx == PW'(NUM_POOLS - 1)) begin
              state <= ST_OUT;
            end else begin
              pidx <= pidx + PW'(1);
            end
          end else begin
            kcnt <= kcnt + mpba_pkg::CNT_W'(1);
          end
          if (cur_cnt == '0) begin
            heads[pidx] <= NULL_IDX;
          end else begin
            if (kcnt == '0) begin
              heads[pidx] <= pos;
            end
            pos <= LW'(add_sum);
          end
        end
        ST_ALLOC: begin
          if (!pool_ok || head_sel >= NULL_IDX) begin
            res_status <= mpba_pkg::STATUS_EMPTY;
            res_grant  <= '0;
          end else begin
            heads[pool_q[PW-1:0]] <= ram_rdata;
            if (use_cnt < NULL_IDX) begin
              use_cnt <= use_cnt + LW'(1);
            end
            res_status <= mpba_pkg::STATUS_OK;
            res_grant  <= head_sel;
          end
          state <= ST_OUT;
        end
        ST_FREE: begin
          if (pool_ok && blk_ok) begin
            heads[pool_q[PW-1:0]] <= LW'(blk_q);
            if (use_cnt != '0) begin
              use_cnt <= use_cnt - LW'(1);
            end
          end
          res_status <= mpba_pkg::STATUS_OK;
          res_grant  <= '0;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_grant  <= mpba_pkg::GRANT_W'(res_grant);
            rsp_use    <= mpba_pkg::USE_W'(use_cnt);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MPBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `MPBA_ASSERT_SAME(a_carve_pool_range, clk, rst, state == ST_CARVE, 32'(pidx) < 32'(NUM_POOLS))
  `MPBA_ASSERT_SAME(a_grant_zero_on_error, clk, rst, rsp_valid && rsp_err, rsp_grant == '0)
  `MPBA_ASSERT_SAME(a_use_bounded, clk, rst, 1'b1, 32'(use_cnt) <= 32'(TOTAL_BLOCKS))

endmodule
`default_nettype wire

@@ rtl/core/mpba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mpba_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/mpba_cfg.sv @@
// APB register file holding the per-pool block counts used at init.
`default_nettype none
module mpba_cfg #(
  parameter int NUM_POOLS = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mpba_pkg::APB_AW-1:0]       paddr,
  input  wire logic [mpba_pkg::APB_DW-1:0]       pwdata,
  output logic      [mpba_pkg::APB_DW-1:0]       prdata,
  output logic      [NUM_POOLS-1:0][mpba_pkg::CNT_W-1:0] counts
);

  logic [mpba_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[mpba_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Pools beyond the register list keep a count of zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        counts[p] <= (p < mpba_pkg::CFG_REGS) ? mpba_pkg::CNT_RESET : '0;
      end
    end else if (wr_en) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        if (p < mpba_pkg::CFG_REGS && reg_idx == mpba_pkg::REG_IDX_W'(p)) begin
          counts[p] <= pwdata[mpba_pkg::CNT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (p < mpba_pkg::CFG_REGS && reg_idx == mpba_pkg::REG_IDX_W'(p)) begin
        prdata = mpba_pkg::APB_DW'(counts[p]);
      end
    end
  end

endmodule
`default_nettype wire
